@@ rtl/core/crp_pkg.sv @@
// ----------------------------------------------------------------------------
// crp_pkg
// shared constants, tables and controller/datapath types for the camera rgb
// to prophoto converter
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int COEF_BITS_DEF  = 20;
  localparam int PRO_W          = 23;
  localparam int DER_W          = 24;
  localparam int MAT_FRAC       = 18;
  localparam int NUM_ROWS       = 3;
  localparam int NUM_COEF       = 9;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;

  localparam logic signed [DER_W-1:0] DER_MAX = 24'sh7fffff;
  localparam logic signed [DER_W-1:0] DER_MIN = -24'sh800000;

  // xyz to prophoto, signed q.20
  localparam logic signed [PRO_W-1:0] PROPHOTO [NUM_COEF] = '{
     23'sd2455633, -23'sd1069855,  -23'sd274927,
    -23'sd1028235,  23'sd2048680,    23'sd28127,
       23'sd27216,    -23'sd96328,  23'sd1326893
  };

  // cofactor terms: adj[k] = a[mc0]*a[mp0] - a[mc1]*a[mp1]
  localparam logic [3:0] ADJ_MC [2*NUM_COEF] = '{
    4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
    4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1
  };
  localparam logic [3:0] ADJ_MP [2*NUM_COEF] = '{
    4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
    4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3
  };

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,
    OP_PREP    = 4'd2,
    OP_MAC     = 4'd3,
    OP_ADJ_ST  = 4'd4,
    OP_DET_ST  = 4'd5,
    OP_T_ST    = 4'd6,
    OP_DIV     = 4'd7,
    OP_COEF_ST = 4'd8,
    OP_ZERO    = 4'd9,
    OP_PX_MAC  = 4'd10,
    OP_PX_FIN  = 4'd11,
    OP_OUT     = 4'd12
  } crp_op_t;

  typedef enum logic [1:0] {
    MC_A   = 2'd0,
    MC_ADJ = 2'd1,
    MC_TM  = 2'd2
  } crp_mc_sel_t;

  typedef enum logic [1:0] {
    MP_A = 2'd0,
    MP_P = 2'd1,
    MP_S = 2'd2
  } crp_mp_sel_t;

  typedef struct packed {
    crp_op_t     op;
    logic        clr;
    logic        sub;
    crp_mc_sel_t mc_sel;
    logic [3:0]  mc_idx;
    crp_mp_sel_t mp_sel;
    logic [3:0]  mp_idx;
    logic [3:0]  k;
  } crp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic rb_ok;
    logic out_free;
  } crp_sts_t;

endpackage

@@ rtl/core/crp_if.sv @@
// ----------------------------------------------------------------------------
// crp channel interfaces
// pixel request channel and result channel, valid/ready with payload
// ----------------------------------------------------------------------------
interface crp_pix_if #(
  parameter int PIXEL_BITS = crp_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] red_in;
  logic [PIXEL_BITS-1:0] green_in;
  logic [PIXEL_BITS-1:0] blue_in;
  logic                  start_of_image;

  modport source (output valid, red_in, green_in, blue_in, start_of_image, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, start_of_image, output ready);
endinterface

interface crp_res_if #(
  parameter int PIXEL_BITS = crp_pkg::PIXEL_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [PIXEL_BITS+3:0]   red_out;
  logic signed [PIXEL_BITS+3:0]   green_out;
  logic signed [PIXEL_BITS+3:0]   blue_out;
  logic                           matrix_singular;
  logic                           clipped;

  modport source (output valid, red_out, green_out, blue_out, matrix_singular, clipped,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, matrix_singular, clipped,
                  output ready);
endinterface

@@ rtl/core/crp_ctrl.sv @@
// ----------------------------------------------------------------------------
// crp_ctrl
// sequencer for matrix rebuild and per-pixel conversion, drives datapath ops
// ----------------------------------------------------------------------------
module crp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_soi,
  output logic              in_ready,
  output crp_pkg::crp_cmd_t cmd,
  input  crp_pkg::crp_sts_t sts
);
  import crp_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_PREP  = 15'h0002,
    S_ADJ   = 15'h0004,
    S_ADJ_W = 15'h0008,
    S_DET   = 15'h0010,
    S_DET_W = 15'h0020,
    S_DCHK  = 15'h0040,
    S_T     = 15'h0080,
    S_T_W   = 15'h0100,
    S_N     = 15'h0200,
    S_N_W   = 15'h0400,
    S_DIV_W = 15'h0800,
    S_PX    = 15'h1000,
    S_PXF   = 15'h2000,
    S_OUT   = 15'h4000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] r_r, r_nxt;
  logic [1:0] c_r, c_nxt;
  logic [1:0] j_r, j_nxt;
  logic [3:0] k;
  logic [4:0] adj_sel;
  logic       last;

  assign k        = {2'b00, r_r} * 4'd3 + {2'b00, c_r};
  assign adj_sel  = {k, j_r[0]};
  assign last     = (r_r == 2'd2) && (c_r == 2'd2);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.k     = k;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          r_nxt     = 2'd0;
          c_nxt     = 2'd0;
          j_nxt     = 2'd0;
          state_nxt = in_soi ? S_PREP : S_PX;
        end
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        state_nxt = S_ADJ;
      end
      S_ADJ: begin
        cmd.op     = OP_MAC;
        cmd.clr    = (j_r == 2'd0);
        cmd.sub    = j_r[0];
        cmd.mc_sel = MC_A;
        cmd.mc_idx = ADJ_MC[adj_sel];
        cmd.mp_sel = MP_A;
        cmd.mp_idx = ADJ_MP[adj_sel];
        state_nxt  = S_ADJ_W;
      end
      S_ADJ_W: begin
        if (!sts.mul_busy) begin
          if (j_r[0]) begin
            cmd.op = OP_ADJ_ST;
            j_nxt  = 2'd0;
            if (last) begin
              r_nxt     = 2'd0;
              c_nxt     = 2'd0;
              state_nxt = S_DET;
            end else begin
              c_nxt     = (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
              r_nxt     = (c_r == 2'd2) ? r_r + 2'd1 : r_r;
              state_nxt = S_ADJ;
            end
          end else begin
            j_nxt     = 2'd1;
            state_nxt = S_ADJ;
          end
        end
      end
      S_DET: begin
        cmd.op     = OP_MAC;
        cmd.clr    = (j_r == 2'd0);
        cmd.mc_sel = MC_ADJ;
        cmd.mc_idx = {2'b00, j_r} * 4'd3;
        cmd.mp_sel = MP_A;
        cmd.mp_idx = {2'b00, j_r};
        state_nxt  = S_DET_W;
      end
      S_DET_W: begin
        if (!sts.mul_busy) begin
          if (j_r == 2'd2) begin
            cmd.op    = OP_DET_ST;
            j_nxt     = 2'd0;
            state_nxt = S_DCHK;
          end else begin
            j_nxt     = j_r + 2'd1;
            state_nxt = S_DET;
          end
        end
      end
      S_DCHK: begin
        if (sts.rb_ok) begin
          state_nxt = S_T;
        end else begin
          cmd.op    = OP_ZERO;
          state_nxt = S_PX;
        end
      end
      S_T: begin
        cmd.op     = OP_MAC;
        cmd.clr    = (j_r == 2'd0);
        cmd.mc_sel = MC_ADJ;
        cmd.mc_idx = {2'b00, j_r} * 4'd3 + {2'b00, c_r};
        cmd.mp_sel = MP_P;
        cmd.mp_idx = {2'b00, r_r} * 4'd3 + {2'b00, j_r};
        state_nxt  = S_T_W;
      end
      S_T_W: begin
        if (!sts.mul_busy) begin
          if (j_r == 2'd2) begin
            cmd.op    = OP_T_ST;
            j_nxt     = 2'd0;
            state_nxt = S_N;
          end else begin
            j_nxt     = j_r + 2'd1;
            state_nxt = S_T;
          end
        end
      end
      S_N: begin
        cmd.op     = OP_MAC;
        cmd.clr    = 1'b1;
        cmd.mc_sel = MC_TM;
        cmd.mp_sel = MP_S;
        cmd.mp_idx = {2'b00, c_r};
        state_nxt  = S_N_W;
      end
      S_N_W: begin
        if (!sts.mul_busy) begin
          cmd.op    = OP_DIV;
          state_nxt = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (!sts.div_busy) begin
          cmd.op = OP_COEF_ST;
          if (last) begin
            r_nxt     = 2'd0;
            c_nxt     = 2'd0;
            state_nxt = S_PX;
          end else begin
            c_nxt     = (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
            r_nxt     = (c_r == 2'd2) ? r_r + 2'd1 : r_r;
            state_nxt = S_T;
          end
        end
      end
      S_PX: begin
        cmd.op     = OP_PX_MAC;
        cmd.clr    = (c_r == 2'd0);
        cmd.mp_idx = {2'b00, c_r};
        if (c_r == 2'd2) begin
          state_nxt = S_PXF;
        end else begin
          c_nxt = c_r + 2'd1;
        end
      end
      S_PXF: begin
        cmd.op     = OP_PX_FIN;
        cmd.mc_idx = {2'b00, r_r};
        c_nxt      = 2'd0;
        if (r_r == 2'd2) begin
          r_nxt     = 2'd0;
          state_nxt = S_OUT;
        end else begin
          r_nxt     = r_r + 2'd1;
          state_nxt = S_PX;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r     <= 2'd0;
      c_r     <= 2'd0;
      j_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

@@ rtl/core/crp_dp.sv @@
// ----------------------------------------------------------------------------
// crp_dp
// config registers, bit-serial multiply-accumulate and divider for the matrix
// rebuild, derived matrix store, pixel multiply-accumulate and output register
// ----------------------------------------------------------------------------
module crp_dp #(
  parameter int PIXEL_BITS = crp_pkg::PIXEL_BITS_DEF,
  parameter int COEF_BITS  = crp_pkg::COEF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  crp_pkg::crp_cmd_t               cmd,
  output crp_pkg::crp_sts_t               sts,
  input  logic [PIXEL_BITS-1:0]           in_red,
  input  logic [PIXEL_BITS-1:0]           in_green,
  input  logic [PIXEL_BITS-1:0]           in_blue,
  input  logic                            cfg_we,
  input  logic [crp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [3*COEF_BITS-1:0]          cfg_wdata,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic signed [PIXEL_BITS+3:0]    out_red,
  output logic signed [PIXEL_BITS+3:0]    out_green,
  output logic signed [PIXEL_BITS+3:0]    out_blue,
  output logic                            out_sing,
  output logic                            out_clip
);
  import crp_pkg::*;

  localparam int A_W   = COEF_BITS;
  localparam int S_W   = COEF_BITS + 2;
  localparam int ADJ_W = 2 * COEF_BITS + 1;
  localparam int DET_W = 3 * COEF_BITS + 3;
  localparam int T_W   = ADJ_W + PRO_W + 2;
  localparam int N_W   = T_W + S_W;
  localparam int ACC_W = N_W + 2;
  localparam int MB_W  = (S_W > PRO_W) ? S_W : PRO_W;
  localparam int MC_W  = $clog2(MB_W + 1);
  localparam int DC_W  = $clog2(N_W + 1);
  localparam int OW    = PIXEL_BITS + 4;
  localparam int PX_W  = DER_W + PIXEL_BITS + 3;
  localparam int OMAX  = 2 ** (OW - 1) - 1;

  // config and rebuild operands
  logic [3*COEF_BITS-1:0]  cfg_row_r [NUM_ROWS];
  logic signed [A_W-1:0]   a_cfg [NUM_COEF];
  logic signed [S_W-1:0]   s_cfg [NUM_ROWS];
  logic signed [A_W-1:0]   a_r [NUM_COEF];
  logic signed [S_W-1:0]   s_r [NUM_ROWS];
  logic                    s_ok_r;
  logic signed [ADJ_W-1:0] adj_r [NUM_COEF];
  logic [DET_W-1:0]        den_r;
  logic                    det_neg_r;
  logic                    rb_ok_r;
  logic [T_W-1:0]          tm_r;
  logic                    tneg_r;

  // serial multiplier
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] mc_r;
  logic signed [ACC_W-1:0] mc_ext;
  logic [MB_W-1:0]         mp_r;
  logic signed [MB_W:0]    mp_ext;
  logic [MB_W-1:0]         mp_mag;
  logic                    mneg_r;
  logic [MC_W-1:0]         mcnt_r;

  // serial divider
  logic [N_W-1:0]          div_n_r;
  logic [N_W-1:0]          q_r;
  logic [DET_W-1:0]        rem_r;
  logic [DET_W:0]          rem_sh;
  logic                    qbit;
  logic [DC_W-1:0]         dcnt_r;
  logic [N_W-1:0]          q2;

  // derived matrix and pixel path
  logic signed [DER_W-1:0] m_r [NUM_COEF];
  logic                    sing_r;
  logic signed [DER_W-1:0] coef;
  logic signed [DET_W-1:0] det_v;
  logic signed [T_W-1:0]   t_v;
  logic [PIXEL_BITS-1:0]   px_r [NUM_ROWS];
  logic signed [PIXEL_BITS:0] x_sel;
  logic signed [PX_W-1:0]  px_prod;
  logic signed [PX_W-1:0]  acc_px_r;
  logic [PX_W-1:0]         px_mag;
  logic [PX_W-1:0]         px_rnd;
  logic signed [OW-1:0]    px_res;
  logic                    px_clip;
  logic signed [OW-1:0]    res_r [NUM_ROWS];
  logic                    clip_r;
  logic                    out_valid_r;

  always_comb begin
    for (int rr = 0; rr < NUM_ROWS; rr++) begin
      s_cfg[rr] = '0;
      for (int cc = 0; cc < 3; cc++) begin
        a_cfg[rr*3+cc] = cfg_row_r[rr][cc*COEF_BITS +: COEF_BITS];
        s_cfg[rr]      = s_cfg[rr] + S_W'(a_cfg[rr*3+cc]);
      end
    end
  end

  always_comb begin
    case (cmd.mc_sel)
      MC_A:    mc_ext = ACC_W'(a_r[cmd.mc_idx]);
      MC_ADJ:  mc_ext = ACC_W'(adj_r[cmd.mc_idx]);
      MC_TM:   mc_ext = ACC_W'(tm_r);
      default: mc_ext = '0;
    endcase
    case (cmd.mp_sel)
      MP_A:    mp_ext = (MB_W+1)'(a_r[cmd.mp_idx]);
      MP_P:    mp_ext = (MB_W+1)'(PROPHOTO[cmd.mp_idx]);
      MP_S:    mp_ext = (MB_W+1)'(s_r[cmd.mp_idx[1:0]]);
      default: mp_ext = '0;
    endcase
    mp_mag = mp_ext[MB_W] ? MB_W'(-mp_ext) : MB_W'(mp_ext);
  end

  assign det_v  = acc_r[DET_W-1:0];
  assign t_v    = acc_r[T_W-1:0];
  assign rem_sh = {rem_r, div_n_r[N_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den_r});
  assign q2     = q_r >> 2;

  always_comb begin
    if (tneg_r) begin
      coef = (q2 > N_W'(2 ** (DER_W - 1))) ? DER_MIN : -DER_W'(q2);
    end else begin
      coef = (q2 > N_W'(DER_MAX)) ? DER_MAX : DER_W'(q2);
    end
  end

  assign x_sel   = {1'b0, px_r[cmd.mp_idx[1:0]]};
  assign px_prod = PX_W'(m_r[cmd.k]) * PX_W'(x_sel);

  always_comb begin
    px_mag  = acc_px_r[PX_W-1] ? PX_W'(-acc_px_r) : PX_W'(acc_px_r);
    px_rnd  = (px_mag + PX_W'(2 ** (MAT_FRAC - 1))) >> MAT_FRAC;
    px_clip = 1'b0;
    if (!acc_px_r[PX_W-1]) begin
      if (px_rnd > PX_W'(OMAX)) begin
        px_res  = OW'(OMAX);
        px_clip = 1'b1;
      end else begin
        px_res = OW'(px_rnd);
      end
    end else begin
      if (px_rnd > PX_W'(OMAX) + PX_W'(1)) begin
        px_res  = -OW'(OMAX) - OW'(1);
        px_clip = 1'b1;
      end else begin
        px_res = -OW'(px_rnd);
      end
    end
  end

  // control state and reset-valued stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROWS; i++) cfg_row_r[i] <= '0;
      for (int i = 0; i < NUM_COEF; i++) m_r[i] <= '0;
      sing_r      <= 1'b0;
      mcnt_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROW0: cfg_row_r[0] <= cfg_wdata;
          REG_ROW1: cfg_row_r[1] <= cfg_wdata;
          REG_ROW2: cfg_row_r[2] <= cfg_wdata;
          default:  ;
        endcase
      end
      if (cmd.op == OP_MAC) begin
        mcnt_r <= MC_W'(MB_W);
      end else if (mcnt_r != '0) begin
        mcnt_r <= mcnt_r - MC_W'(1);
      end
      if (cmd.op == OP_DIV) begin
        dcnt_r <= DC_W'(N_W);
      end else if (dcnt_r != '0) begin
        dcnt_r <= dcnt_r - DC_W'(1);
      end
      if (cmd.op == OP_COEF_ST) begin
        m_r[cmd.k] <= coef;
        sing_r     <= 1'b0;
      end
      if (cmd.op == OP_ZERO) begin
        for (int i = 0; i < NUM_COEF; i++) m_r[i] <= '0;
        sing_r <= 1'b1;
      end
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      px_r[0] <= in_red;
      px_r[1] <= in_green;
      px_r[2] <= in_blue;
    end
    if (cmd.op == OP_PREP) begin
      a_r    <= a_cfg;
      s_r    <= s_cfg;
      s_ok_r <= (s_cfg[0] > 0) && (s_cfg[1] > 0) && (s_cfg[2] > 0);
    end
    if (cmd.op == OP_MAC) begin
      mc_r   <= mc_ext;
      mp_r   <= mp_mag;
      mneg_r <= mp_ext[MB_W] ^ cmd.sub;
      if (cmd.clr) acc_r <= '0;
    end else if (mcnt_r != '0) begin
      if (mp_r[0]) acc_r <= mneg_r ? acc_r - mc_r : acc_r + mc_r;
      mc_r <= mc_r <<< 1;
      mp_r <= mp_r >> 1;
    end
    if (cmd.op == OP_ADJ_ST) adj_r[cmd.k] <= acc_r[ADJ_W-1:0];
    if (cmd.op == OP_DET_ST) begin
      det_neg_r <= det_v[DET_W-1];
      den_r     <= det_v[DET_W-1] ? DET_W'(-det_v) : DET_W'(det_v);
      rb_ok_r   <= s_ok_r && (det_v != '0);
    end
    if (cmd.op == OP_T_ST) begin
      tneg_r <= t_v[T_W-1] ^ det_neg_r;
      tm_r   <= t_v[T_W-1] ? T_W'(-t_v) : T_W'(t_v);
    end
    if (cmd.op == OP_DIV) begin
      div_n_r <= N_W'(acc_r) + (N_W'(den_r) << 1);
      rem_r   <= '0;
      q_r     <= '0;
    end else if (dcnt_r != '0) begin
      rem_r   <= qbit ? DET_W'(rem_sh - {1'b0, den_r}) : rem_sh[DET_W-1:0];
      q_r     <= {q_r[N_W-2:0], qbit};
      div_n_r <= div_n_r << 1;
    end
    if (cmd.op == OP_PX_MAC) begin
      acc_px_r <= (cmd.clr ? PX_W'(0) : acc_px_r) + px_prod;
    end
    if (cmd.op == OP_PX_FIN) begin
      res_r[cmd.mc_idx[1:0]] <= px_res;
      clip_r <= ((cmd.mc_idx == 4'd0) ? 1'b0 : clip_r) | px_clip;
    end
    if (cmd.op == OP_OUT) begin
      out_red   <= res_r[0];
      out_green <= res_r[1];
      out_blue  <= res_r[2];
      out_sing  <= sing_r;
      out_clip  <= clip_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.mul_busy = (mcnt_r != '0);
  assign sts.div_busy = (dcnt_r != '0);
  assign sts.rb_ok    = rb_ok_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

@@ rtl/core/camera_rgb_to_prophoto_converter.sv @@
// a pixel without start_of_image is taken in S_IDLE; its result is registered after
//   nine multiply-accumulates in three row rounds, once the output register is free
// a new pixel is taken only once the last result is registered, via the single pixel multiplier
// start_of_image first adds the matrix rebuild, done by the bit-serial multiplier
//   and divider
// synchronous active-low reset clears config, derived matrix and the flag
// ----------------------------------------------------------------------------
// camera_rgb_to_prophoto_converter
// camera rgb to linear prophoto rgb with a matrix rebuilt at start of image
// ----------------------------------------------------------------------------
module camera_rgb_to_prophoto_converter #(
  parameter int PIXEL_BITS = crp_pkg::PIXEL_BITS_DEF,
  parameter int COEF_BITS  = crp_pkg::COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  crp_pix_if.sink                       in_pix,
  crp_res_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [crp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [3*COEF_BITS-1:0]        cfg_wdata
);
  import crp_pkg::*;

  crp_cmd_t cmd;
  crp_sts_t sts;

  crp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .in_soi   (in_pix.start_of_image),
    .in_ready (in_pix.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  crp_dp #(
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_red    (in_pix.red_in),
    .in_green  (in_pix.green_in),
    .in_blue   (in_pix.blue_in),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .out_red   (out_res.red_out),
    .out_green (out_res.green_out),
    .out_blue  (out_res.blue_out),
    .out_sing  (out_res.matrix_singular),
    .out_clip  (out_res.clipped)
  );

endmodule

@@ rtl/core/crp_chk.sv @@
// ----------------------------------------------------------------------------
// crp_chk
// port-level checks for the converter, bound to the top level
// ----------------------------------------------------------------------------
module crp_chk #(
  parameter int OW = crp_pkg::PIXEL_BITS_DEF + 4
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [OW-1:0] out_red,
  input logic signed [OW-1:0] out_green,
  input logic signed [OW-1:0] out_blue,
  input logic                 out_sing,
  input logic                 out_clip
);
  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a request");

  a_one_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r <= 2'd1)
    else $error("request taken with too many results outstanding");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sing |-> out_red == '0 && out_green == '0 && out_blue == '0 && !out_clip)
    else $error("singular matrix gave nonzero result");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind camera_rgb_to_prophoto_converter crp_chk #(
  .OW (PIXEL_BITS + 4)
) u_crp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_red   (out_res.red_out),
  .out_green (out_res.green_out),
  .out_blue  (out_res.blue_out),
  .out_sing  (out_res.matrix_singular),
  .out_clip  (out_res.clipped)
);
